// ===== sv/cbfa_pkg.sv =====
package cbfa_pkg;

   // field widths of the stream payloads
   localparam int IDX_W    = 10;
   localparam int LEN_W    = 11;
   localparam int TKT_W    = 12;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int CSR_W    = 11;

   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_PARK    = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_PARKED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd4;

   localparam logic [CSR_W-1:0] RING_SIZE_RESET = 11'd1024;

   // commands from the sequencer to the run tracker
   typedef struct packed {
      logic init;
      logic sample;
      logic taken;
      logic merge;
      logic close;
   } track_ctrl_type;

endpackage

// ===== sv/circular_best_fit_slot_allocator_top.sv =====
// Best-fit allocator over a circular ring of ring_size slots. A park transaction takes
// a contiguous block from the start of the shortest free run that fits (lowest start on
// a tie, possibly wrapping past the last slot) and records it under a ticket; a release
// transaction frees the block of a ticket again. The occupancy map and the ticket table
// sit in single-port RAMs, and one transaction is worked on at a time. For a park the
// map is scanned once, one slot a cycle through its read port, then the block is
// written one slot a cycle. For a release the stored start is reduced into the ring by
// repeated subtraction, then min(length, ring_size) slots of the block are freed one
// slot a cycle. A result not yet taken holds the block in its last step. After reset a
// clearing pass over max(MAX_SLOTS, MAX_TICKETS) addresses (4096 by default) empties
// both RAMs before the first transaction is taken; writes to ring_size are taken at
// any time.
module circular_best_fit_slot_allocator_top #(
   parameter int MAX_SLOTS   = 1024,
   parameter int MAX_TICKETS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // slot_index[9:0], slot_taken[10], request_length[21:11], release_ticket[33:22]
   input  logic [39:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // block_start[9:0], block_length[20:10], wraps_around[21], ticket[33:22]
   output logic [39:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);

   localparam int AW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int NW        = $clog2(MAX_SLOTS + 1);
   localparam int TW        = $clog2(MAX_TICKETS);
   localparam int EW        = 1 + AW + NW;
   localparam int CLR_DEPTH = (MAX_SLOTS > MAX_TICKETS) ? MAX_SLOTS : MAX_TICKETS;
   localparam int CLW       = $clog2(CLR_DEPTH);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_MERGE,
      S_PICK,
      S_DECIDE,
      S_FILL,
      S_TKT_RD,
      S_TKT_WAIT,
      S_MOD,
      S_FREE,
      S_TKT_WR,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   logic [cbfa_pkg::IDX_W-1:0]    req_slot_index;
   logic                          req_slot_taken;
   logic [cbfa_pkg::LEN_W-1:0]    req_request_length;
   logic [cbfa_pkg::TKT_W-1:0]    req_release_ticket;
   logic [cbfa_pkg::OP_W-1:0]     req_operation;

   logic [CLW-1:0]                clr_ff, clr_in;
   logic [cbfa_pkg::CSR_W-1:0]    ring_size_ff, ring_size_in;
   logic [NW-1:0]                 n_now;
   logic [NW-1:0]                 n_ff, n_in;
   logic [TW-1:0]                 ctr_ff, ctr_in;
   logic [TW-1:0]                 tkt_ff, tkt_in;
   logic [TW-1:0]                 rt_ff, rt_in;
   logic [cbfa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [AW-1:0]                 res_start_ff, res_start_in;
   logic [NW-1:0]                 res_len_ff, res_len_in;
   logic                          res_wrap_ff, res_wrap_in;
   logic [NW-1:0]                 scan_ff, scan_in;
   logic                          rd_pend_ff, rd_pend_in;
   logic [AW-1:0]                 rd_idx_ff, rd_idx_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [NW-1:0]                 cnt_ff, cnt_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cbfa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [cbfa_pkg::IDX_W-1:0]    rsp_start_ff, rsp_start_in;
   logic [cbfa_pkg::LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic                          rsp_wrap_ff, rsp_wrap_in;
   logic [cbfa_pkg::TKT_W-1:0]    rsp_ticket_ff, rsp_ticket_in;

   logic                          map_we;
   logic [AW-1:0]                 map_addr;
   logic                          map_wdata;
   logic                          map_rdata;
   logic                          tab_we;
   logic [TW-1:0]                 tab_addr;
   logic [EW-1:0]                 tab_wdata;
   logic [EW-1:0]                 tab_rdata;

   cbfa_pkg::track_ctrl_type      trk_ctrl;
   logic                          trk_found;
   logic [AW-1:0]                 trk_best_start;

   logic                          req_fire;
   logic [TW-1:0]                 ctr_next;
   logic [AW-1:0]                 pos_step;
   logic [NW-1:0]                 ent_len;
   logic [AW-1:0]                 ent_start;

   assign req_slot_index     = req_tdata[9:0];
   assign req_slot_taken     = req_tdata[10];
   assign req_request_length = req_tdata[21:11];
   assign req_release_ticket = req_tdata[33:22];
   assign req_operation      = req_tuser;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ring size in use: zero reads as one, oversize as the map depth
   always_comb begin
      if (ring_size_ff == '0) begin
         n_now = NW'(1);
      end else if (32'(ring_size_ff) > MAX_SLOTS) begin
         n_now = NW'(MAX_SLOTS);
      end else begin
         n_now = NW'(ring_size_ff);
      end
   end

   assign ctr_next  = (32'(ctr_ff) + 1 >= MAX_TICKETS) ? TW'(1) : ctr_ff + TW'(1);
   assign pos_step  = ((NW+1)'(pos_ff) + (NW+1)'(1) == (NW+1)'(n_ff)) ? '0 : pos_ff + AW'(1);
   assign ent_len   = tab_rdata[NW-1:0];
   assign ent_start = tab_rdata[EW-2:NW];

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ring_size_in  = ring_size_ff;
      n_in          = n_ff;
      ctr_in        = ctr_ff;
      tkt_in        = tkt_ff;
      rt_in         = rt_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_len_in    = res_len_ff;
      res_wrap_in   = res_wrap_ff;
      scan_in       = scan_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_wrap_in   = rsp_wrap_ff;
      rsp_ticket_in = rsp_ticket_ff;
      map_we        = 1'b0;
      map_addr      = '0;
      map_wdata     = 1'b0;
      tab_we        = 1'b0;
      tab_addr      = '0;
      tab_wdata     = '0;
      trk_ctrl      = '0;

      if (csr_valid && csr_ready) begin
         ring_size_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            map_we   = (32'(clr_ff) < MAX_SLOTS);
            map_addr = AW'(clr_ff);
            tab_we   = (32'(clr_ff) < MAX_TICKETS);
            tab_addr = TW'(clr_ff);
            clr_in   = clr_ff + CLW'(1);
            if (32'(clr_ff) == CLR_DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               n_in          = n_now;
               res_start_in  = '0;
               res_len_in    = '0;
               res_wrap_in   = 1'b0;
               case (req_operation)
                  cbfa_pkg::OP_LOAD: begin
                     map_we        = (32'(req_slot_index) < MAX_SLOTS);
                     map_addr      = AW'(req_slot_index);
                     map_wdata     = req_slot_taken;
                     res_status_in = cbfa_pkg::ST_LOADED;
                     tkt_in        = '0;
                     state_in      = S_RESP;
                  end
                  cbfa_pkg::OP_PARK: begin
                     tkt_in = ctr_ff;
                     ctr_in = ctr_next;
                     if ((req_request_length == '0) ||
                         (32'(req_request_length) > 32'(n_now))) begin
                        res_status_in = cbfa_pkg::ST_NO_ROOM;
                        state_in      = S_TKT_WR;
                     end else begin
                        res_status_in = cbfa_pkg::ST_PARKED;
                        res_len_in    = NW'(req_request_length);
                        trk_ctrl.init = 1'b1;
                        scan_in       = '0;
                        state_in      = S_SCAN;
                     end
                  end
                  cbfa_pkg::OP_RELEASE: begin
                     tkt_in = ctr_ff;
                     ctr_in = ctr_next;
                     rt_in  = TW'(req_release_ticket);
                     if ((req_release_ticket == '0) ||
                         (32'(req_release_ticket) >= MAX_TICKETS)) begin
                        res_status_in = cbfa_pkg::ST_UNKNOWN;
                        state_in      = S_TKT_WR;
                     end else begin
                        state_in = S_TKT_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // read data comes back in the cycle after the address
            map_addr        = AW'(scan_ff);
            trk_ctrl.sample = rd_pend_ff;
            trk_ctrl.taken  = map_rdata;
            if (scan_ff < n_ff) begin
               scan_in    = scan_ff + NW'(1);
               rd_pend_in = 1'b1;
               rd_idx_in  = AW'(scan_ff);
            end else if (rd_pend_ff) begin
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            trk_ctrl.merge = 1'b1;
            state_in       = S_PICK;
         end
         S_PICK: begin
            trk_ctrl.close = 1'b1;
            state_in       = S_DECIDE;
         end
         S_DECIDE: begin
            if (trk_found) begin
               res_start_in = trk_best_start;
               pos_in       = trk_best_start;
               cnt_in       = res_len_ff;
               state_in     = S_FILL;
            end else begin
               res_status_in = cbfa_pkg::ST_NO_ROOM;
               res_len_in    = '0;
               state_in      = S_TKT_WR;
            end
         end
         S_FILL: begin
            map_we    = 1'b1;
            map_addr  = pos_ff;
            map_wdata = 1'b1;
            pos_in    = pos_step;
            cnt_in    = cnt_ff - NW'(1);
            if (cnt_ff == NW'(1)) begin
               state_in = S_TKT_WR;
            end
         end
         S_TKT_RD: begin
            tab_addr = rt_ff;
            state_in = S_TKT_WAIT;
         end
         S_TKT_WAIT: begin
            tab_addr = rt_ff;
            if (tab_rdata[EW-1]) begin
               tab_we        = 1'b1;
               res_status_in = cbfa_pkg::ST_RELEASED;
               res_start_in  = ent_start;
               res_len_in    = ent_len;
               pos_in        = ent_start;
               cnt_in        = (ent_len < n_ff) ? ent_len : n_ff;
               state_in      = S_MOD;
            end else begin
               res_status_in = cbfa_pkg::ST_UNKNOWN;
               state_in      = S_TKT_WR;
            end
         end
         S_MOD: begin
            // a start beyond a shrunk ring is brought back into it
            if ((NW+1)'(pos_ff) >= (NW+1)'(n_ff)) begin
               pos_in = pos_ff - AW'(n_ff);
            end else begin
               state_in = S_FREE;
            end
         end
         S_FREE: begin
            map_we   = 1'b1;
            map_addr = pos_ff;
            pos_in   = pos_step;
            cnt_in   = cnt_ff - NW'(1);
            if (cnt_ff == NW'(1)) begin
               state_in = S_TKT_WR;
            end
         end
         S_TKT_WR: begin
            // the ticket just taken is cleared, or filled by a granted park
            tab_we   = 1'b1;
            tab_addr = tkt_ff;
            if (res_status_ff == cbfa_pkg::ST_PARKED) begin
               tab_wdata = {1'b1, res_start_ff, res_len_ff};
            end
            res_wrap_in = ((NW+1)'(res_start_ff) + (NW+1)'(res_len_ff)) > (NW+1)'(n_ff);
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = cbfa_pkg::IDX_W'(res_start_ff);
               rsp_len_in    = cbfa_pkg::LEN_W'(res_len_ff);
               rsp_wrap_in   = res_wrap_ff;
               rsp_ticket_in = cbfa_pkg::TKT_W'(tkt_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      tkt_ff        <= tkt_in;
      rt_ff         <= rt_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_len_ff    <= res_len_in;
      res_wrap_ff   <= res_wrap_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_wrap_ff   <= rsp_wrap_in;
      rsp_ticket_ff <= rsp_ticket_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ring_size_ff <= cbfa_pkg::RING_SIZE_RESET;
         ctr_ff       <= TW'(1);
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ring_size_ff <= ring_size_in;
         ctr_ff       <= ctr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   cbfa_ram #(
      .WIDTH (1),
      .DEPTH (MAX_SLOTS)
   ) u_map_ram (
      .clock (clock),
      .we    (map_we),
      .addr  (map_addr),
      .wdata (map_wdata),
      .rdata (map_rdata)
   );

   cbfa_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_TICKETS)
   ) u_ticket_ram (
      .clock (clock),
      .we    (tab_we),
      .addr  (tab_addr),
      .wdata (tab_wdata),
      .rdata (tab_rdata)
   );

   cbfa_run_tracker #(
      .AW (AW),
      .NW (NW)
   ) u_run_tracker (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (trk_ctrl),
      .idx        (rd_idx_ff),
      .want       (res_len_ff),
      .found      (trk_found),
      .best_start (trk_best_start)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'b0, rsp_ticket_ff, rsp_wrap_ff, rsp_len_ff, rsp_start_ff};

   a_ticket_nonzero: assert property (@(posedge clock) disable iff (reset)
      (ctr_ff != '0) && (32'(ctr_ff) < MAX_TICKETS))
      else $error("ticket counter out of range");

   a_result_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_RESP))
      else $error("result raised outside the response step");

   a_pos_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL || state_ff == S_FREE) |-> ((NW+1)'(pos_ff) < (NW+1)'(n_ff)))
      else $error("block position outside the ring");

   a_parked_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == cbfa_pkg::ST_PARKED) |-> (rsp_len_ff != '0))
      else $error("granted block with zero length");

endmodule

// ===== sv/cbfa_ram.sv =====
module cbfa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                      wdata,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/cbfa_run_tracker.sv =====
module cbfa_run_tracker #(
   parameter int AW = 10,
   parameter int NW = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cbfa_pkg::track_ctrl_type ctrl,
   input  logic [AW-1:0]           idx,
   input  logic [NW-1:0]           want,
   output logic                    found,
   output logic [AW-1:0]           best_start
);

   logic          seen_ff, seen_in;
   logic          found_ff, found_in;
   logic [NW-1:0] lead_len_ff, lead_len_in;
   logic [NW-1:0] cur_len_ff, cur_len_in;
   logic [AW-1:0] cur_start_ff, cur_start_in;
   logic [NW-1:0] best_len_ff, best_len_in;
   logic [AW-1:0] best_start_ff, best_start_in;
   logic          cand_ok;

   // the one compare unit: does the current run beat the best so far
   assign cand_ok = (cur_len_ff >= want) &&
                    (!found_ff || (cur_len_ff < best_len_ff) ||
                     ((cur_len_ff == best_len_ff) && (cur_start_ff < best_start_ff)));

   always_comb begin
      seen_in       = seen_ff;
      found_in      = found_ff;
      lead_len_in   = lead_len_ff;
      cur_len_in    = cur_len_ff;
      cur_start_in  = cur_start_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      if (ctrl.init) begin
         seen_in      = 1'b0;
         found_in     = 1'b0;
         lead_len_in  = '0;
         cur_len_in   = '0;
         cur_start_in = '0;
      end else if (ctrl.sample) begin
         if (!ctrl.taken) begin
            if (cur_len_ff == '0) begin
               cur_start_in = idx;
            end
            cur_len_in = cur_len_ff + NW'(1);
         end else begin
            if (!seen_ff) begin
               // leading run is held back to join the trailing run
               lead_len_in = cur_len_ff;
               seen_in     = 1'b1;
            end else if (cand_ok) begin
               found_in      = 1'b1;
               best_len_in   = cur_len_ff;
               best_start_in = cur_start_ff;
            end
            cur_len_in = '0;
         end
      end else if (ctrl.merge) begin
         cur_len_in = cur_len_ff + lead_len_ff;
         if (cur_len_ff == '0) begin
            cur_start_in = '0;
         end
      end else if (ctrl.close) begin
         if (cand_ok) begin
            found_in      = 1'b1;
            best_len_in   = cur_len_ff;
            best_start_in = cur_start_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      lead_len_ff   <= lead_len_in;
      cur_start_ff  <= cur_start_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      if (reset) begin
         seen_ff    <= 1'b0;
         found_ff   <= 1'b0;
         cur_len_ff <= '0;
      end else begin
         seen_ff    <= seen_in;
         found_ff   <= found_in;
         cur_len_ff <= cur_len_in;
      end
   end

   assign found      = found_ff;
   assign best_start = best_start_ff;

endmodule
